@@ rtl/eh_pkg.sv @@
`timescale 1ns / 1ps

package eh_pkg;

  // Stack geometry
  localparam int StackDepth = 64;
  localparam int CntW       = $clog2(StackDepth + 1);

  // Field widths
  localparam int FrameW = 10;
  localparam int AddrW  = 32;
  localparam int RegW   = 16;
  localparam int DepthW = 11;
  localparam int OpW    = 2;
  localparam int StatW  = 3;

  // Stream payload widths, whole bytes
  localparam int InDataW  = 72;
  localparam int OutDataW = 80;
  localparam int OutUsedW = FrameW + AddrW + RegW + 1 + DepthW + CntW;

  // One handler entry
  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic [AddrW-1:0]  address;
    logic [RegW-1:0]   dest;
    logic              traps;
  } entry_t;

  // Shift control shared by every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  typedef enum logic [OpW-1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_DROP     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE        = 3'd0,
    ST_POPPED      = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_CAUGHT      = 3'd3,
    ST_UNCAUGHT    = 3'd4,
    ST_OVERFLOW    = 3'd5,
    ST_NO_FRAME    = 3'd6,
    ST_NOT_PENDING = 3'd7
  } status_e;

endpackage

@@ rtl/exception_handler_stack.sv @@
`timescale 1ns / 1ps
// Each item runs through the control sequence: push, pop and a dispatch with nothing pending go
//   straight to S_RESP; pop-frame goes through S_DROP, one dropped handler per step; dispatch goes
//   through S_SEARCH, popping or skipping handlers, then S_UNWIND when caught, dropping handlers
//   of frames above the owner, and S_RESP loads the output register.
// One item at a time: the input reopens once the result sits in the output register.
//   Reset clears the handler count, control and output valid.
module exception_handler_stack (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // frame_number, catch_address, dest_register, only_traps, pending, user_thrown,
  // frame_depth (lowest bit first)
  input  logic [eh_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode
  input  logic [eh_pkg::OpW-1:0]       s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_frame, out_address, out_register, out_only_traps, new_depth, entries_left,
  // zero fill (lowest bit first)
  output logic [eh_pkg::OutDataW-1:0]  m_axis_tdata,
  // status
  output logic [eh_pkg::StatW-1:0]     m_axis_tuser
);
  import eh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_SEARCH,
    S_UNWIND,
    S_RESP
  } state_e;

  localparam logic [CntW-1:0] CntFull = CntW'(StackDepth);

  // Input fields
  op_e               in_op;
  logic [FrameW-1:0] in_frame;
  entry_t            in_entry;
  logic              in_pending;
  logic              in_thrown;
  logic [DepthW-1:0] in_depth;

  assign in_op            = op_e'(s_axis_tuser);
  assign in_frame         = s_axis_tdata[9:0];
  assign in_entry.frame   = s_axis_tdata[9:0];
  assign in_entry.address = s_axis_tdata[41:10];
  assign in_entry.dest    = s_axis_tdata[57:42];
  assign in_entry.traps   = s_axis_tdata[58];
  assign in_pending       = s_axis_tdata[59];
  assign in_thrown        = s_axis_tdata[60];
  assign in_depth         = s_axis_tdata[71:61];

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [FrameW-1:0] frame_q;
  logic              thrown_q;
  logic [DepthW-1:0] depth_q;
  entry_t            hnd_q;
  status_e           status_q;
  logic [DepthW-1:0] new_depth_q;
  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [StatW-1:0]  out_stat_q;

  // Row of cells, top of stack in cell 0
  entry_t cell_q [StackDepth];
  entry_t top;
  shift_t shift;
  logic   accept;
  logic   not_empty;
  logic   top_user_skip;
  logic   unwind_pop;
  logic   out_free;

  assign top       = cell_q[0];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign not_empty = (count_q != '0);
  assign out_free  = !out_valid_q || m_axis_tready;
  assign top_user_skip = thrown_q && top.traps;
  assign unwind_pop = not_empty && (top.frame > hnd_q.frame) &&
                      ({1'b0, top.frame} < depth_q);

  // Shift control for the row
  always_comb begin
    shift.push = 1'b0;
    shift.pop  = 1'b0;
    case (state_q)
      S_IDLE: begin
        shift.push = accept && (in_op == OP_PUSH) && (count_q != CntFull);
        shift.pop  = accept && (in_op == OP_POP) && not_empty;
      end
      S_DROP:   shift.pop = not_empty && (top.frame == frame_q);
      S_SEARCH: shift.pop = not_empty;
      S_UNWIND: shift.pop = unwind_pop;
      default: ;
    endcase
  end

  for (genvar i = 0; i < StackDepth; i++) begin : g_cell
    entry_t above;
    entry_t below;
    if (i == 0) begin : g_head
      assign above = in_entry;
    end else begin : g_mid_a
      assign above = cell_q[i-1];
    end
    if (i == StackDepth - 1) begin : g_tail
      assign below = cell_q[i];
    end else begin : g_mid_b
      assign below = cell_q[i+1];
    end
    eh_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (shift),
      .above_i (above),
      .below_i (below),
      .entry_o (cell_q[i])
    );
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // Control sequence and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            new_depth_q <= '0;
            case (in_op)
              OP_PUSH: begin
                hnd_q   <= '0;
                state_q <= S_RESP;
                if (count_q == CntFull) begin
                  status_q <= ST_OVERFLOW;
                end else begin
                  status_q <= ST_DONE;
                  count_q  <= count_q + CntW'(1);
                end
              end
              OP_POP: begin
                state_q <= S_RESP;
                if (!not_empty) begin
                  status_q <= ST_EMPTY;
                  hnd_q    <= '0;
                end else begin
                  status_q <= ST_POPPED;
                  hnd_q    <= top;
                  count_q  <= count_q - CntW'(1);
                end
              end
              OP_DROP: begin
                hnd_q    <= '0;
                status_q <= ST_DONE;
                frame_q  <= in_frame;
                state_q  <= S_DROP;
              end
              OP_DISPATCH: begin
                hnd_q <= '0;
                if (!in_pending) begin
                  status_q <= ST_NOT_PENDING;
                  state_q  <= S_RESP;
                end else begin
                  thrown_q <= in_thrown;
                  depth_q  <= in_depth;
                  state_q  <= S_SEARCH;
                end
              end
              default: ;
            endcase
          end
        end
        // Drop top entries of one frame
        S_DROP: begin
          if (not_empty && (top.frame == frame_q)) begin
            count_q <= count_q - CntW'(1);
          end else begin
            state_q <= S_RESP;
          end
        end
        // Pop handlers until one takes this exception
        S_SEARCH: begin
          if (!not_empty) begin
            status_q    <= ST_UNCAUGHT;
            new_depth_q <= '0;
            state_q     <= S_RESP;
          end else begin
            count_q <= count_q - CntW'(1);
            if (!top_user_skip) begin
              hnd_q <= top;
              if ((depth_q == '0) || ({1'b0, top.frame} >= depth_q)) begin
                status_q    <= ST_NO_FRAME;
                new_depth_q <= depth_q;
                state_q     <= S_RESP;
              end else begin
                status_q    <= ST_CAUGHT;
                new_depth_q <= {1'b0, top.frame} + DepthW'(1);
                state_q     <= S_UNWIND;
              end
            end
          end
        end
        // Drop handlers of frames above the owner
        S_UNWIND: begin
          if (unwind_pop) begin
            count_q <= count_q - CntW'(1);
            depth_q <= {1'b0, top.frame} + DepthW'(1);
          end else begin
            state_q <= S_RESP;
          end
        end
        // Hand the result to the output register
        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_stat_q  <= status_q;
            out_data_q  <= {(OutDataW - OutUsedW)'(0), count_q, new_depth_q, hnd_q.traps,
                            hnd_q.dest, hnd_q.address, hnd_q.frame};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_stat_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("handler count beyond stack depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op == OP_PUSH) && (count_q != CntFull)) |=>
      (count_q == $past(count_q) + CntW'(1)))
    else $error("push did not grow the stack");

  a_uncaught_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_stat_q == ST_UNCAUGHT)) |->
      ((out_data_q[76:70] == '0) && (out_data_q[69:59] == '0)))
    else $error("uncaught result with handlers or frames left");

  a_caught_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_stat_q == ST_CAUGHT)) |->
      (out_data_q[69:59] == {1'b0, out_data_q[9:0]} + DepthW'(1)))
    else $error("caught result with wrong frame count");

endmodule

@@ rtl/eh_cell.sv @@
`timescale 1ns / 1ps

module eh_cell (
  input  logic            clk_i,
  input  eh_pkg::shift_t  ctl_i,
  input  eh_pkg::entry_t  above_i,
  input  eh_pkg::entry_t  below_i,
  output eh_pkg::entry_t  entry_o
);
  import eh_pkg::*;

  entry_t entry_q;

  // Take the upper neighbour on push, the lower one on pop, else hold
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      entry_q <= above_i;
    end else if (ctl_i.pop) begin
      entry_q <= below_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import eh_pkg::*;

  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 150;
  localparam int FrameLimit    = 1024;

  // Input transfer layout; the first member sits in the top bits, so frame lands at bit 0
  typedef struct packed {
    logic [DepthW-1:0] depth;
    logic              thrown;
    logic              pending;
    logic              traps;
    logic [RegW-1:0]   dest;
    logic [AddrW-1:0]  address;
    logic [FrameW-1:0] frame;
  } request_t;

  // One expected result
  typedef struct packed {
    status_e           status;
    logic [FrameW-1:0] frame;
    logic [AddrW-1:0]  address;
    logic [RegW-1:0]   dest;
    logic              traps;
    logic [DepthW-1:0] new_depth;
    logic [CntW-1:0]   left;
  } verdict_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [OpW-1:0]      s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatW-1:0]    m_axis_tuser;

  exception_handler_stack DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Shadow of the handler stack and the results still owed by the block
  entry_t   shadow_handlers [StackDepth];
  int       shadow_count;
  verdict_t verdict_q [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int call_depth;
  bit feed_idle;
  bit sink_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drop every top handler owned by one frame
  function automatic void shadow_drop(int fr);
    while (shadow_count > 0 && int'(shadow_handlers[shadow_count - 1].frame) == fr)
      shadow_count--;
  endfunction

  // Apply one operation to the shadow stack and work out the block's answer
  function automatic verdict_t predict_handler_op(op_e op, request_t rq);
    verdict_t v;
    entry_t   h;
    bit       found;
    int       d;
    v = '0;
    v.status = ST_DONE;
    h = '0;
    d = int'(rq.depth);
    case (op)
      OP_PUSH: begin
        if (shadow_count >= StackDepth) begin
          v.status = ST_OVERFLOW;
        end else begin
          h.frame   = rq.frame;
          h.address = rq.address;
          h.dest    = rq.dest;
          h.traps   = rq.traps;
          shadow_handlers[shadow_count] = h;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          v.status = ST_EMPTY;
        end else begin
          shadow_count--;
          h = shadow_handlers[shadow_count];
          v.status = ST_POPPED;
        end
      end
      OP_DROP: shadow_drop(int'(rq.frame));
      default: begin
        if (!rq.pending) begin
          v.status = ST_NOT_PENDING;
        end else begin
          // pop until a handler accepts this kind of exception
          found = 1'b0;
          while (shadow_count > 0 && !found) begin
            shadow_count--;
            h = shadow_handlers[shadow_count];
            if (!(rq.thrown && h.traps)) found = 1'b1;
          end
          if (!found) begin
            h = '0;
            shadow_count = 0;
            v.status = ST_UNCAUGHT;
          end else if (d == 0 || int'(h.frame) >= d) begin
            v.new_depth = rq.depth;
            v.status = ST_NO_FRAME;
          end else begin
            // unwind frames above the owner
            while (d - 1 > int'(h.frame)) begin
              shadow_drop(d - 1);
              d--;
            end
            v.new_depth = d[DepthW-1:0];
            v.status = ST_CAUGHT;
          end
        end
      end
    endcase
    if (v.status inside {ST_POPPED, ST_CAUGHT, ST_NO_FRAME}) begin
      v.frame   = h.frame;
      v.address = h.address;
      v.dest    = h.dest;
      v.traps   = h.traps;
    end
    v.left = shadow_count[CntW-1:0];
    return v;
  endfunction

  // Fields that the operation does not use still carry random bits
  function automatic request_t noise_request();
    request_t rq;
    rq.frame   = FrameW'($urandom_range(0, FrameLimit - 1));
    rq.address = $urandom;
    rq.dest    = RegW'($urandom_range(0, 65535));
    rq.traps   = 1'($urandom_range(0, 1));
    rq.pending = 1'($urandom_range(0, 1));
    rq.thrown  = 1'($urandom_range(0, 1));
    rq.depth   = DepthW'($urandom_range(0, FrameLimit));
    return rq;
  endfunction

  // Mostly shallow call stacks, now and then one near the frame limit
  function automatic int pick_call_depth();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 16);
    if (r < 9) return $urandom_range(17, 200);
    return $urandom_range(FrameLimit - 24, FrameLimit);
  endfunction

  // Send one item; hold it until the transfer and record what it should give
  task automatic send_request(input op_e op, input request_t rq, output verdict_t v);
    int gap;
    gap = feed_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rq;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    v = predict_handler_op(op, rq);
    verdict_q.push_back(v);
  endtask

  task automatic push_handler(int fr, logic [AddrW-1:0] addr, logic [RegW-1:0] dest,
                              logic traps);
    request_t rq;
    verdict_t v;
    rq = noise_request();
    rq.frame   = FrameW'(fr);
    rq.address = addr;
    rq.dest    = dest;
    rq.traps   = traps;
    send_request(OP_PUSH, rq, v);
  endtask

  task automatic dispatch(logic pending, logic thrown, int depth);
    request_t rq;
    verdict_t v;
    rq = noise_request();
    rq.pending = pending;
    rq.thrown  = thrown;
    rq.depth   = DepthW'(depth);
    send_request(OP_DISPATCH, rq, v);
  endtask

  task automatic pop_top();
    verdict_t v;
    send_request(OP_POP, noise_request(), v);
  endtask

  task automatic drop_frame(int fr);
    request_t rq;
    verdict_t v;
    rq = noise_request();
    rq.frame = FrameW'(fr);
    send_request(OP_DROP, rq, v);
  endtask

  // Extremes of the fields and each corner of every operation
  task automatic test_directed();
    feed_idle = 1'b1;
    sink_idle = 1'b1;
    pop_top();                       // empty stack
    drop_frame(0);                   // nothing to drop
    dispatch(1'b1, 1'b0, 5);         // uncaught on an empty stack
    dispatch(1'b0, 1'b1, 1024);      // nothing pending
    push_handler(1023, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    pop_top();
    push_handler(0, 32'h0, 16'h0, 1'b0);
    push_handler(2, 32'hA5A5_5A5A, 16'h1234, 1'b1);
    push_handler(5, 32'h0000_1000, 16'h0042, 1'b0);
    push_handler(5, 32'h0000_2000, 16'h0043, 1'b1);
    dispatch(1'b1, 1'b1, 1024);      // skip a trap-only handler, unwind to frame 5
    dispatch(1'b1, 1'b0, 6);         // trap-only handler catches a trap
    push_handler(7, 32'h8000_0001, 16'h8001, 1'b0);
    dispatch(1'b1, 1'b0, 0);         // no frames at all
    push_handler(9, 32'h7FFF_FFFE, 16'h7FFE, 1'b0);
    dispatch(1'b1, 1'b0, 9);         // owner frame not live
    drop_frame(3);                   // top belongs to another frame
    push_handler(4, 32'h1111_1111, 16'h2222, 1'b0);
    push_handler(4, 32'h3333_3333, 16'h4444, 1'b1);
    drop_frame(4);
    push_handler(1, 32'h5555_5555, 16'h6666, 1'b1);
    dispatch(1'b1, 1'b1, 2);
    push_handler(3, 32'h9999_9999, 16'hAAAA, 1'b1);
    dispatch(1'b1, 1'b1, 4);         // only trap-only handlers left: uncaught
  endtask

  // Fill the stack, push past the top, pop and refill, then dispatch exceptions into the full stack
  task automatic test_full_stack();
    verdict_t v;
    feed_idle = 1'b0;
    sink_idle = 1'b1;
    call_depth = 1;
    while (shadow_count < StackDepth) begin
      if ($urandom_range(0, 3) == 0 && call_depth < FrameLimit) call_depth++;
      push_handler(call_depth - 1, $urandom, RegW'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
    end
    push_handler(call_depth - 1, $urandom, RegW'($urandom_range(0, 65535)), 1'b0);
    push_handler(0, $urandom, RegW'($urandom_range(0, 65535)), 1'b1);
    pop_top();
    push_handler(call_depth - 1, $urandom, RegW'($urandom_range(0, 65535)), 1'b0);
    push_handler(FrameLimit - 1, $urandom, RegW'($urandom_range(0, 65535)), 1'b0);
    feed_idle = 1'b1;
    dispatch(1'b1, 1'b1, call_depth);
    dispatch(1'b1, 1'b0, call_depth);
    send_request(OP_DISPATCH, '{depth: 0, thrown: 0, pending: 1, traps: 0, dest: 0,
                                address: 0, frame: 0}, v);
  endtask

  // Call-shaped sequences: handlers follow the call depth, exceptions unwind it
  task automatic test_random_traffic(int count);
    request_t rq;
    verdict_t v;
    op_e      op;
    int       r;
    call_depth = pick_call_depth();
    for (int i = 0; i < count; i++) begin
      if (i % 250 == 0) begin
        feed_idle = $urandom_range(0, 1);
        sink_idle = $urandom_range(0, 1);
      end
      rq = noise_request();
      r = $urandom_range(0, 99);
      if (r < 6) begin
        op = op_e'($urandom_range(0, 3));
      end else if (r < 50) begin
        op = OP_PUSH;
        if ($urandom_range(0, 3) == 0)
          call_depth = (call_depth + 3 > FrameLimit) ? FrameLimit
                                                     : call_depth + $urandom_range(1, 3);
        r = $urandom_range(0, 9);
        if (r < 8) rq.frame = FrameW'(call_depth - 1);
        else if (r < 9) rq.frame = FrameW'($urandom_range(0, call_depth - 1));
        rq.traps = ($urandom_range(0, 9) < 3);
      end else if (r < 60) begin
        op = OP_POP;
      end else if (r < 72) begin
        op = OP_DROP;
        if (shadow_count > 0 && $urandom_range(0, 4) != 0)
          rq.frame = shadow_handlers[shadow_count - 1].frame;
      end else begin
        op = OP_DISPATCH;
        rq.pending = ($urandom_range(0, 9) != 0);
        r = $urandom_range(0, 99);
        if (r < 85) rq.depth = DepthW'(call_depth);
        else if (r < 90) rq.depth = '0;
      end
      send_request(op, rq, v);
      // follow the call depth the way the machine would
      if (op == OP_DISPATCH && v.status == ST_CAUGHT && v.new_depth != 0)
        call_depth = int'(v.new_depth);
      else if (op == OP_DISPATCH && v.status == ST_UNCAUGHT)
        call_depth = pick_call_depth();
      else if (op == OP_DROP && int'(rq.frame) == call_depth - 1 && call_depth > 1)
        call_depth--;
    end
  endtask

  // Receiver: when sink_idle is set, draw a stall before taking each result
  initial begin : result_sink
    int hold;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      hold = sink_idle ? $urandom_range(0, 4) : 0;
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic check_field(string name, logic [AddrW-1:0] want, logic [AddrW-1:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, got status %0d data %h",
                 $time, m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        check_field("status", AddrW'(want.status), AddrW'(m_axis_tuser));
        check_field("out_frame", AddrW'(want.frame), AddrW'(m_axis_tdata[9:0]));
        check_field("out_address", want.address, m_axis_tdata[41:10]);
        check_field("out_register", AddrW'(want.dest), AddrW'(m_axis_tdata[57:42]));
        check_field("out_only_traps", AddrW'(want.traps), AddrW'(m_axis_tdata[58]));
        check_field("new_depth", AddrW'(want.new_depth), AddrW'(m_axis_tdata[69:59]));
        check_field("entries_left", AddrW'(want.left), AddrW'(m_axis_tdata[76:70]));
        check_field("zero fill", '0, AddrW'(m_axis_tdata[OutDataW-1:OutUsedW]));
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    shadow_count  = 0;
    call_depth    = 1;
    feed_idle     = 1'b0;
    sink_idle     = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_PUSH;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_full_stack();
    test_random_traffic(1750);
    s_axis_tvalid <= 1'b0;

    // wait out the outstanding results, then a little longer for strays
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
